### src/stle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sprite tile list expander.
// Used by every module of the block; depends on nothing.
package stle_pkg;

    // field widths
    localparam int POS_X_W   = 16;
    localparam int POS_Y_W   = 8;
    localparam int WORD_W    = 16;
    localparam int INDEX_W   = 11;
    localparam int COUNT_W   = 12;
    localparam int CFG_IDX_W = 2;

    // tile word decode
    localparam int FLIP_X_POS  = 11;
    localparam int FLIP_Y_POS  = 12;
    localparam int PAL_LO_POS  = 13;
    localparam int PAL_HI_POS  = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 2'd1;

    // register reset values
    localparam logic [WORD_W-1:0]  OFFSET_RESET = 16'h0000;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 12'd2048;

    // sequencer states
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } stle_state_t;

    // decoded sprite held for the whole expansion
    typedef struct packed {
        logic signed [POS_X_W-1:0] px;
        logic signed [POS_Y_W-1:0] py;
        logic [INDEX_W-1:0]        base;
        logic                      fx;
        logic                      fy;
        logic [1:0]                pal;
        logic [1:0]                rows_m1;
        logic [1:0]                cols_m1;
    } stle_sprite_t;

    // one step of the sequencer toward the tile unit
    typedef struct packed {
        logic       load;
        logic [1:0] row;
        logic [1:0] col;
        logic       last;
    } stle_step_t;

endpackage

### src/stle_seq.sv
`timescale 1ns / 1ps
// Row and column sequencer that walks the tile grid of one sprite.
// Depends on stle_pkg.
module stle_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           rows_m1,
    input  logic [1:0]           cols_m1,
    input  logic                 out_free,
    output logic                 idle,
    output stle_pkg::stle_step_t step
);
    import stle_pkg::*;

    stle_state_t state_reg, state_next;
    logic [1:0]  row_reg, row_next;
    logic [1:0]  col_reg, col_next;
    logic        row_end, col_end;

    // state and grid position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    assign row_end = (row_reg == rows_m1);
    assign col_end = (col_reg == cols_m1);

    // next state and step control
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        idle       = 1'b0;
        step.load  = 1'b0;
        step.row   = row_reg;
        step.col   = col_reg;
        step.last  = row_end && col_end;
        case (state_reg)
            SEQ_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                // one tile per cycle whenever the output register can take it
                if (out_free)
                begin
                    step.load = 1'b1;
                    if (col_end)
                    begin
                        col_next = 2'd0;
                        if (row_end)
                            state_next = SEQ_IDLE;
                        else
                            row_next = row_reg + 2'd1;
                    end
                    else
                    begin
                        col_next = col_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

### src/stle_calc.sv
`timescale 1ns / 1ps
// Shared tile unit: position, mirrored pattern index and range check of one
// tile per step, with the output register. Depends on stle_pkg.
module stle_calc (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stle_pkg::stle_sprite_t               sprite,
    input  stle_pkg::stle_step_t                 step,
    input  logic [stle_pkg::COUNT_W-1:0]         pattern_count,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [stle_pkg::POS_X_W:0]    tile_x,
    output logic signed [stle_pkg::POS_Y_W:0]    tile_y,
    output logic                                 tile_flip_x,
    output logic                                 tile_flip_y,
    output logic [5:0]                           palette_bits,
    output logic [stle_pkg::INDEX_W-1:0]         tile_index,
    output logic                                 tile_valid,
    output logic                                 last_tile
);
    import stle_pkg::*;

    logic [1:0]           vr, vc;
    logic [2:0]           rows;
    logic [3:0]           col_off;
    logic [INDEX_W-1:0]   ti_next;
    logic [POS_X_W:0]     x_next;
    logic [POS_Y_W:0]     y_next;
    logic                 valid_next;

    logic                 out_valid_reg;
    logic [POS_X_W:0]     tile_x_reg;
    logic [POS_Y_W:0]     tile_y_reg;
    logic                 flip_x_reg, flip_y_reg;
    logic [5:0]           palette_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic                 valid_reg;
    logic                 last_reg;

    // mirrored row and column, column-major pattern index
    always_comb
    begin
        vc         = sprite.fx ? (sprite.cols_m1 - step.col) : step.col;
        vr         = sprite.fy ? (sprite.rows_m1 - step.row) : step.row;
        rows       = {1'b0, sprite.rows_m1} + 3'd1;
        col_off    = {2'b00, vc} * {1'b0, rows};
        ti_next    = sprite.base + {9'd0, vr} + {7'd0, col_off};
        valid_next = ({1'b0, ti_next} < pattern_count);
        x_next     = {sprite.px[POS_X_W-1], sprite.px}
                     + {{(POS_X_W-4){1'b0}}, step.col, 3'b000};
        y_next     = {sprite.py[POS_Y_W-1], sprite.py}
                     + {{(POS_Y_W-4){1'b0}}, step.row, 3'b000};
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (step.load)
        begin
            tile_x_reg  <= x_next;
            tile_y_reg  <= y_next;
            flip_x_reg  <= sprite.fx;
            flip_y_reg  <= sprite.fy;
            palette_reg <= {sprite.pal, 4'b0000};
            index_reg   <= ti_next;
            valid_reg   <= valid_next;
            last_reg    <= step.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tile_x       = tile_x_reg;
    assign tile_y       = tile_y_reg;
    assign tile_flip_x  = flip_x_reg;
    assign tile_flip_y  = flip_y_reg;
    assign palette_bits = palette_reg;
    assign tile_index   = index_reg;
    assign tile_valid   = valid_reg;
    assign last_tile    = last_reg;

endmodule

### src/sprite_tile_list_expander.sv
`timescale 1ns / 1ps
// Sprite tile list expander: expands one sprite attribute entry into its tiles.
// Top level; depends on stle_pkg, stle_seq and stle_calc.
//
// Usage:
//   The input channel (in_valid / in_ready) takes one sprite per transfer.
//   The tile offset register is subtracted from the tile word, which is then decoded.
//   The output channel (out_valid / out_ready) then gives one tile per
//   transfer, row by row and column by column, last_tile marking the end.
//   A sprite of R rows and C columns gives R*C tiles, 1 to 16.
//   The sprite register captures the sprite and the sequencer enters its run
//   state; the row and column sequencer then issues one tile per cycle,
//   whenever the output register can take it, to the shared tile unit,
//   and in_ready stays low until the last tile is issued.
//   A stalled receiver holds the output register, and the sequencer waits.
//   The next sprite may be taken while the last tile still waits.
//   Config writes (cfg_valid / cfg_ready, always ready) go to index 0 for
//   the tile offset and index 1 for the pattern count; other indexes are
//   dropped. Write them only while the block is idle.
//   Reset clears the offset to 0, the pattern count to 2048, and empties
//   the output register.
module sprite_tile_list_expander (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [stle_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stle_pkg::WORD_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [stle_pkg::POS_Y_W-1:0]  sprite_y,
    input  logic [3:0]                           sprite_size,
    input  logic [stle_pkg::WORD_W-1:0]          sprite_tile_word,
    input  logic signed [stle_pkg::POS_X_W-1:0]  sprite_x,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [stle_pkg::POS_X_W:0]    tile_x,
    output logic signed [stle_pkg::POS_Y_W:0]    tile_y,
    output logic                                 tile_flip_x,
    output logic                                 tile_flip_y,
    output logic [5:0]                           palette_bits,
    output logic [stle_pkg::INDEX_W-1:0]         tile_index,
    output logic                                 tile_valid,
    output logic                                 last_tile
);
    import stle_pkg::*;

    logic [WORD_W-1:0]  offset_reg;
    logic [COUNT_W-1:0] count_reg;
    stle_sprite_t       sprite_reg;
    logic [WORD_W-1:0]  word_adj;
    logic               idle;
    logic               start;
    logic               out_free;
    stle_step_t         step;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_TILE_OFFSET)
                offset_reg <= cfg_data;
            else if (cfg_index == CFG_PATTERN_COUNT)
                count_reg <= cfg_data[COUNT_W-1:0];
        end
    end

    // sprite capture and tile word decode
    assign in_ready = idle;
    assign start    = in_valid && in_ready;
    assign word_adj = sprite_tile_word - offset_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sprite_reg.px      <= sprite_x;
            sprite_reg.py      <= sprite_y;
            sprite_reg.base    <= word_adj[INDEX_W-1:0];
            sprite_reg.fx      <= word_adj[FLIP_X_POS];
            sprite_reg.fy      <= word_adj[FLIP_Y_POS];
            sprite_reg.pal     <= word_adj[PAL_HI_POS:PAL_LO_POS];
            sprite_reg.rows_m1 <= sprite_size[1:0];
            sprite_reg.cols_m1 <= sprite_size[3:2];
        end
    end

    // output register may load when empty or being drained
    assign out_free = !out_valid || out_ready;

    stle_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .rows_m1  (sprite_reg.rows_m1),
        .cols_m1  (sprite_reg.cols_m1),
        .out_free (out_free),
        .idle     (idle),
        .step     (step)
    );

    stle_calc u_calc (
        .clk           (clk),
        .rst_n         (rst_n),
        .sprite        (sprite_reg),
        .step          (step),
        .pattern_count (count_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .tile_x        (tile_x),
        .tile_y        (tile_y),
        .tile_flip_x   (tile_flip_x),
        .tile_flip_y   (tile_flip_y),
        .palette_bits  (palette_bits),
        .tile_index    (tile_index),
        .tile_valid    (tile_valid),
        .last_tile     (last_tile)
    );

endmodule

### src/stle_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the sprite tile list expander, bound to the top level.
// Depends on stle_pkg and sprite_tile_list_expander.
module stle_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [stle_pkg::POS_X_W:0]    tile_x,
    input logic [stle_pkg::INDEX_W-1:0]         tile_index,
    input logic                                 last_tile
);
    import stle_pkg::*;

    // a sprite transfer starts an expansion, so input closes next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after a sprite transfer");

    // a pending tile that is not the last means the sprite is still expanding
    a_busy_mid_sprite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_tile) |-> !in_ready)
        else $error("input open while a sprite is partly expanded");

    // any tile still waiting when a new sprite enters ends the previous one
    a_take_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_valid) |-> last_tile)
        else $error("new sprite taken before the last tile was issued");

    // a stalled tile holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(tile_x) && $stable(tile_index)
             && $stable(last_tile)))
        else $error("stalled tile changed");

endmodule

bind sprite_tile_list_expander stle_checker u_stle_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tile_x     (tile_x),
    .tile_index (tile_index),
    .last_tile  (last_tile)
);
